// ===== design/iss_pkg.sv =====
// iss_pkg: shared constants and types for the insertion sorter.
// No dependencies. Used by the cell, the interfaces and the top level.
package iss_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [0:0] {
    ST_FILL,
    ST_EMIT
  } st_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== design/iss_in_if.sv =====
// iss_in_if: request channel carrying one value to insert.
// Depends on iss_pkg.
interface iss_in_if
  import iss_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== design/iss_out_if.sv =====
// iss_out_if: result channel carrying one sorted element.
// Depends on iss_pkg.
interface iss_out_if
  import iss_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] sorted_value;
  logic                    end_of_set;
  logic                    overflow;

  modport source (output valid, output sorted_value, output end_of_set, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input overflow,
                  output ready);
endinterface

// ===== design/iss_cell.sv =====
// iss_cell: one slot of the sorting chain.
// Depends on iss_pkg. Instantiated CAPACITY times by insertion_sorter_unit.
module iss_cell
  import iss_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic signed [VAL_W-1:0] new_val,
  input  logic                    occ,
  input  logic                    left_occ,
  input  logic                    left_gt,
  input  logic signed [VAL_W-1:0] left_val,
  input  logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0] val,
  output logic                    gt
);

  // strict compare keeps equal entries below the new one (stable)
  assign gt = occ && (val > new_val);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_gt) begin
        val <= left_val;
      end else if (gt || (!occ && left_occ)) begin
        val <= new_val;
      end
    end else if (ctrl.shift) begin
      val <= right_val;
    end
  end

endmodule

// ===== design/insertion_sorter_unit.sv =====
// insertion_sorter_unit: streaming insertion sort over a chain of cells.
// Depends on iss_pkg, iss_in_if, iss_out_if and iss_cell.
//
//  channel | dir | payload                              | role
//  --------+-----+--------------------------------------+-------------------------
//  din     | in  | value[31:0] signed, last             | one element per request
//  dout    | out | sorted_value[31:0], end_of_set, ovfl | one sorted element each
//
// Cycles: an element is inserted in the cycle it is accepted; all cells
//   compare against it and shift in parallel, so din takes one request
//   per cycle while filling.
// After the request marked last, the set drains from cell 0 at one result
//   per cycle while dout.ready is high; din is held off until all are taken.
// Reset (rst, synchronous): fill count, drop flag and state clear; cell
//   contents are left as they are and only occupied cells are ever read.
// Stalls: dout is driven straight from cell 0 and held while dout.ready is
//   low; din.ready is low for the whole drain.
module insertion_sorter_unit
  import iss_pkg::*;
(
  input logic         clk,
  input logic         rst,
  iss_in_if.sink      din,
  iss_out_if.source   dout
);

  st_t              state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             dropped, dropped_next;
  cell_ctrl_t       ctrl;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic                    cell_gt  [CAPACITY];
  logic                    cell_occ [CAPACITY];

  logic in_acc, out_acc, full;

  assign full    = (count == CNT_W'(CAPACITY));
  assign in_acc  = din.valid && din.ready;
  assign out_acc = dout.valid && dout.ready;

  // ---------------------------------------------------------------------
  // Control: fill while accepting, then drain the chain to dout.
  // ready is high in ST_FILL and valid is high in ST_EMIT, so the other
  // side of each handshake alone decides acceptance there.
  // ---------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    ctrl.insert  = 1'b0;
    ctrl.shift   = 1'b0;
    din.ready    = 1'b0;
    dout.valid   = 1'b0;
    case (state)
      ST_FILL: begin
        din.ready = 1'b1;
        if (din.valid) begin
          if (full) begin
            dropped_next = 1'b1;      // no room: drop, store unchanged
          end else begin
            ctrl.insert = 1'b1;
            count_next  = count + CNT_W'(1);
          end
          if (din.last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        dout.valid = 1'b1;
        if (dout.ready) begin
          ctrl.shift = 1'b1;
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next   = ST_FILL;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_FILL;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain. Cell 0 holds the smallest entry; occupancy is i < count.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    l_occ, l_gt;
    logic signed [VAL_W-1:0] l_val, r_val;

    assign cell_occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
      assign l_val = cell_val[i];
    end else begin : g_body
      assign l_occ = cell_occ[i-1];
      assign l_gt  = cell_gt[i-1];
      assign l_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_val = cell_val[i];     // top slot is vacated on drain
    end else begin : g_mid
      assign r_val = cell_val[i+1];
    end

    iss_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .new_val   (din.value),
      .occ       (cell_occ[i]),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .left_val  (l_val),
      .right_val (r_val),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  assign dout.sorted_value = cell_val[0];
  assign dout.end_of_set   = (count == CNT_W'(1));
  assign dout.overflow     = dropped;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> count != '0)
    else $error("drain with empty chain");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    in_acc && full |=> dropped)
    else $error("drop not recorded");

  a_set_done: assert property (@(posedge clk) disable iff (rst)
    out_acc && dout.end_of_set |=> state == ST_FILL && count == '0 && !dropped)
    else $error("set not cleared after final result");

endmodule

// ===== dv/tb_insertion_sorter_unit.sv =====
`timescale 1ns / 100ps
// tb_insertion_sorter_unit: self-checking bench for insertion_sorter_unit.
// Depends on iss_pkg, iss_in_if, iss_out_if and the design under test.
// Directed rows run first, then random sets; all but pinned rows use a local sort model.
module tb_insertion_sorter_unit;
  import iss_pkg::*;

  localparam int ITEMS       = 250;  // rough request count; ends the stimulus and starts the calm tail
  localparam int CALM_TAIL   = 40;   // last requests run with no idling at all
  localparam int IDLE_LIMIT  = 500;  // cycles with no handshake before giving up
  localparam int SETTLE      = 2 * CAPACITY + 8;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    eos;
    logic                    ovf;
  } sort_result_t;

  // One directed request. Rows with pinned set are one-element sets after
  // reset or an emission, so the single result is typed in: exp_value, marked
  // end of set, no overflow. All other rows go through the sort model.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    pinned;
    logic signed [VAL_W-1:0] exp_value;
  } dir_row_t;

  localparam int NUM_DIRECTED = 26;

  dir_row_t dir_rows [NUM_DIRECTED] = '{
    // single-element sets at the extremes and at -1, straight out of reset
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
    '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
    '{-32'sd1, 1'b1, 1'b1, -32'sd1},
    // mixed set: duplicates, both extremes, zero, arriving out of order
    '{32'sd7,  1'b0, 1'b0, '0},
    '{-32'sd7, 1'b0, 1'b0, '0},
    '{32'sd7,  1'b0, 1'b0, '0},
    '{VAL_MAX, 1'b0, 1'b0, '0},
    '{VAL_MIN, 1'b0, 1'b0, '0},
    '{32'sd0,  1'b1, 1'b0, '0},
    // full store, descending so every insert shifts the whole chain,
    // then a last request that is itself dropped (must not show up)
    '{32'sd16, 1'b0, 1'b0, '0},
    '{32'sd15, 1'b0, 1'b0, '0},
    '{32'sd14, 1'b0, 1'b0, '0},
    '{32'sd13, 1'b0, 1'b0, '0},
    '{32'sd12, 1'b0, 1'b0, '0},
    '{32'sd11, 1'b0, 1'b0, '0},
    '{32'sd10, 1'b0, 1'b0, '0},
    '{32'sd9,  1'b0, 1'b0, '0},
    '{32'sd8,  1'b0, 1'b0, '0},
    '{32'sd7,  1'b0, 1'b0, '0},
    '{32'sd6,  1'b0, 1'b0, '0},
    '{32'sd5,  1'b0, 1'b0, '0},
    '{32'sd4,  1'b0, 1'b0, '0},
    '{32'sd3,  1'b0, 1'b0, '0},
    '{32'sd2,  1'b0, 1'b0, '0},
    '{32'sd1,  1'b0, 1'b0, '0},
    '{-32'sd100, 1'b1, 1'b0, '0}
  };

  logic clk;
  logic rst;

  iss_in_if  din ();
  iss_out_if dout ();

  insertion_sorter_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sort model: private copy of the sorted store, its fill and the drop flag.
  // Results of each set are queued in emission order.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] model_entries [CAPACITY];
  int                      model_fill;
  bit                      model_dropped;
  sort_result_t            pending_results [$];

  int  errors;
  int  requests_sent;
  bit  calm;

  task automatic sorter_accept(input logic signed [VAL_W-1:0] v, input logic l,
                               input logic pinned, input logic signed [VAL_W-1:0] pin_val);
    int           pos;
    sort_result_t r;
    // full store: value is lost, set gets flagged
    if (model_fill >= CAPACITY) begin
      model_dropped = 1'b1;
    end else begin
      // strictly greater entries move up; equal ones stay below (stable)
      pos = model_fill;
      while (pos > 0 && model_entries[pos-1] > v) begin
        model_entries[pos] = model_entries[pos-1];
        pos--;
      end
      model_entries[pos] = v;
      model_fill++;
    end
    if (l) begin
      if (pinned) begin
        r.value = pin_val;
        r.eos   = 1'b1;
        r.ovf   = 1'b0;
        pending_results.push_back(r);
      end else begin
        for (int k = 0; k < model_fill; k++) begin
          r.value = model_entries[k];
          r.eos   = (k == model_fill - 1);
          r.ovf   = model_dropped;
          pending_results.push_back(r);
        end
      end
      model_fill    = 0;
      model_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. valid stays up between back-to-back requests; a gap is
  // a random burst with junk payload and valid low.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic signed [VAL_W-1:0] v, input logic l,
                              input logic pinned, input logic signed [VAL_W-1:0] pin_val);
    din.valid <= 1'b1;
    din.value <= v;
    din.last  <= l;
    do @(posedge clk); while (!din.ready);
    sorter_accept(v, l, pinned, pin_val);
    requests_sent++;
    if (requests_sent >= ITEMS - CALM_TAIL) calm = 1'b1;
    if (!calm && $urandom_range(0, 7) == 0) begin
      din.valid <= 1'b0;
      din.value <= $urandom;
      din.last  <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // value styles: full range, a narrow band (lots of ties), extremes mixed in
  function automatic logic signed [VAL_W-1:0] pick_value(input int style);
    int sel;
    case (style)
      0: return $urandom;
      1: return int'($urandom_range(0, 8)) - 4;
      default: begin
        sel = $urandom_range(0, 4);
        case (sel)
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          3: return '1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side backpressure: stall bursts, single ready cycles and long
  // stretches of ready; no stalls once the tail of the run is reached.
  // ---------------------------------------------------------------------------
  initial begin
    int pick;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 9);
      if (calm || pick >= 3) begin
        dout.ready <= 1'b1;
      end else if (pick == 2) begin
        dout.ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        dout.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        dout.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [VAL_W-1:0] exp_v,
                                      input logic [VAL_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    sort_result_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d eos %b ovf %b",
                 $time, dout.sorted_value, dout.end_of_set, dout.overflow);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("sorted_value", want.value, dout.sorted_value);
        check_field("end_of_set", VAL_W'(want.eos), VAL_W'(dout.end_of_set));
        check_field("overflow", VAL_W'(want.ovf), VAL_W'(dout.overflow));
      end
    end
  end

  // watchdog: too long without any handshake on either side ends the run
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_insertion_sorter_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int set_len;
    int style;
    int shape;
    errors        = 0;
    requests_sent = 0;
    calm          = 1'b0;
    model_fill    = 0;
    model_dropped = 1'b0;
    rst       <= 1'b1;
    din.valid <= 1'b0;
    din.value <= '0;
    din.last  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_request(dir_rows[i].value, dir_rows[i].last, dir_rows[i].pinned,
                   dir_rows[i].exp_value);

    // random sets: mostly short, some near capacity, some past it
    while (requests_sent < ITEMS) begin
      shape = $urandom_range(0, 9);
      if (shape < 7)       set_len = $urandom_range(1, 6);
      else if (shape == 7) set_len = $urandom_range(10, CAPACITY);
      else                 set_len = $urandom_range(CAPACITY + 1, CAPACITY + 5);
      style = $urandom_range(0, 2);
      for (int k = 0; k < set_len; k++)
        send_request(pick_value(style), k == set_len - 1, 1'b0, '0);
    end
    din.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // room for any stray result after the last expected one
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_insertion_sorter_unit passed");
    end else begin
      $display("tb_insertion_sorter_unit failed");
    end
    $finish;
  end

endmodule
